// File: rtl/cmbb_pkg.sv
// ----------------------------------------------------------------------------
// Colour-match bounding box: shared package
// Register indexes, reset values, configuration, result and queue status types.
// ----------------------------------------------------------------------------
package cmbb_pkg;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 12;
   localparam int COLOUR_W = 8;
   localparam int TOL_W = 6;
   localparam int FSIZE_W = 12;
   localparam int SIZE_W = 17;
   localparam int BOX_W = 11;

   localparam logic [FSIZE_W-1:0] FRAME_WIDTH_RESET = 12'd640;
   localparam logic [FSIZE_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET_RED   = 3'd0,
      CSR_TARGET_GREEN = 3'd1,
      CSR_TARGET_BLUE  = 3'd2,
      CSR_TOLERANCE    = 3'd3,
      CSR_FRAME_WIDTH  = 3'd4,
      CSR_FRAME_HEIGHT = 3'd5
   } cmbb_csr_type;

   typedef struct packed {
      logic [COLOUR_W-1:0] target_red;
      logic [COLOUR_W-1:0] target_green;
      logic [COLOUR_W-1:0] target_blue;
      logic [TOL_W-1:0]    tolerance;
      logic [FSIZE_W-1:0]  frame_width;
      logic [FSIZE_W-1:0]  frame_height;
   } cmbb_cfg_type;

   typedef struct packed {
      logic [BOX_W-1:0] box_height;
      logic [BOX_W-1:0] box_width;
      logic [BOX_W-1:0] box_y;
      logic [BOX_W-1:0] box_x;
      logic             found;
   } cmbb_result_type;

   typedef struct packed {
      logic       full;
      logic       empty;
      logic [1:0] count;
   } cmbb_queue_status_type;

endpackage

// File: rtl/cmbb_front.sv
// ----------------------------------------------------------------------------
// Colour-match bounding box: front end
// Classifies each pixel against the target colour and stamps it with its
// column, row and an end-of-frame mark from the raster counters.
// ----------------------------------------------------------------------------
module cmbb_front
   import cmbb_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 2048,
   parameter int CW = 11,
   parameter int RW = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmbb_cfg_type         cfg,
   input  logic                 accept,
   input  logic [REQ_DATA_W-1:0] pixel,
   output logic [CW+RW+1:0]     entry
);

   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [SIZE_W-1:0] w_eff, h_eff, w_last, h_last, fw_ext, fh_ext;
   logic              col_end, row_end, match;

   function automatic logic colour_in_range(input logic [COLOUR_W-1:0] value,
                                            input logic [COLOUR_W-1:0] target,
                                            input logic [TOL_W-1:0] tol);
      logic [COLOUR_W:0] v_hi, t_hi;
      v_hi = {1'b0, value} + {3'b0, tol};
      t_hi = {1'b0, target} + {3'b0, tol};
      return (v_hi >= {1'b0, target}) && ({1'b0, value} <= t_hi);
   endfunction

   always_comb begin
      fw_ext = SIZE_W'(cfg.frame_width);
      fh_ext = SIZE_W'(cfg.frame_height);
      if (cfg.frame_width == '0) begin
         w_eff = SIZE_W'(1);
      end else if (fw_ext > SIZE_W'(MAX_WIDTH)) begin
         w_eff = SIZE_W'(MAX_WIDTH);
      end else begin
         w_eff = fw_ext;
      end
      if (cfg.frame_height == '0) begin
         h_eff = SIZE_W'(1);
      end else if (fh_ext > SIZE_W'(MAX_HEIGHT)) begin
         h_eff = SIZE_W'(MAX_HEIGHT);
      end else begin
         h_eff = fh_ext;
      end
      w_last = w_eff - SIZE_W'(1);
      h_last = h_eff - SIZE_W'(1);
      col_end = SIZE_W'(col_ff) >= w_last;
      row_end = SIZE_W'(row_ff) >= h_last;

      match = colour_in_range(pixel[7:0], cfg.target_red, cfg.tolerance)
           && colour_in_range(pixel[15:8], cfg.target_green, cfg.tolerance)
           && colour_in_range(pixel[23:16], cfg.target_blue, cfg.tolerance);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   assign entry = {match, col_end && row_end, row_ff, col_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: rtl/cmbb_queue.sv
// ----------------------------------------------------------------------------
// Colour-match bounding box: decoupling queue
// Two-entry register queue between the front end and the box tracker.
// ----------------------------------------------------------------------------
module cmbb_queue
   import cmbb_pkg::*;
#(
   parameter int WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      pop_data,
   output cmbb_queue_status_type status
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   assign pop_data = data_ff[rptr_ff];
   assign status.full = count_ff == 2'd2;
   assign status.empty = count_ff == 2'd0;
   assign status.count = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wptr_ff] <= push_data;
      end
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/cmbb_back.sv
// ----------------------------------------------------------------------------
// Colour-match bounding box: box tracker
// Folds classified pixels into the running box and registers one result at
// the end of each frame, then clears the box.
// ----------------------------------------------------------------------------
module cmbb_back
   import cmbb_pkg::*;
#(
   parameter int CW = 11,
   parameter int RW = 11
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [CW+RW+1:0] head,
   input  logic            head_valid,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output cmbb_result_type rsp_result
);

   logic            any_ff, any_in, any_n;
   logic [CW-1:0]   left_ff, left_in, left_n, right_ff, right_in, right_n, col, dx;
   logic [RW-1:0]   top_ff, top_in, top_n, bottom_ff, bottom_in, bottom_n, row, dy;
   logic            match, eof;
   logic            valid_ff, valid_in;
   cmbb_result_type result_ff, result_in;

   assign col = head[CW-1:0];
   assign row = head[CW+RW-1:CW];
   assign eof = head[CW+RW];
   assign match = head[CW+RW+1];

   assign pop = head_valid && (!eof || !valid_ff || rsp_ready);

   always_comb begin
      any_n = any_ff;
      left_n = left_ff;
      right_n = right_ff;
      top_n = top_ff;
      bottom_n = bottom_ff;
      if (match) begin
         any_n = 1'b1;
         if (!any_ff || col < left_ff) left_n = col;
         if (!any_ff || col > right_ff) right_n = col;
         if (!any_ff || row < top_ff) top_n = row;
         if (!any_ff || row > bottom_ff) bottom_n = row;
      end
      dx = right_n - left_n;
      dy = bottom_n - top_n;

      any_in = any_ff;
      left_in = left_ff;
      right_in = right_ff;
      top_in = top_ff;
      bottom_in = bottom_ff;
      result_in = result_ff;
      valid_in = valid_ff && !rsp_ready;
      if (pop) begin
         if (eof) begin
            any_in = 1'b0;
            left_in = '1;
            right_in = '0;
            top_in = '1;
            bottom_in = '0;
            valid_in = 1'b1;
            result_in = '0;
            if (any_n) begin
               result_in.found = 1'b1;
               result_in.box_x = BOX_W'(left_n);
               result_in.box_y = BOX_W'(top_n);
               result_in.box_width = BOX_W'(dx);
               result_in.box_height = BOX_W'(dy);
            end
         end else begin
            any_in = any_n;
            left_in = left_n;
            right_in = right_n;
            top_in = top_n;
            bottom_in = bottom_n;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff <= '0;
         left_ff <= '1;
         right_ff <= '0;
         top_ff <= '1;
         bottom_ff <= '0;
         any_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         result_ff <= result_in;
         left_ff <= left_in;
         right_ff <= right_in;
         top_ff <= top_in;
         bottom_ff <= bottom_in;
         any_ff <= any_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// File: rtl/colour_match_bounding_box_top.sv
// ----------------------------------------------------------------------------
// Colour-match bounding box: top level
// Takes one pixel per cycle and gives one box result per frame.
// A frame's last pixel passes through the queue, then its result is registered;
// this is delayed only while the queue still drains pixels held by a stall.
// Throughput: one pixel per cycle, set by the two-entry queue and the result
// register; pixels stall only while a result waits to be taken.
// Reset clears counters, box, queue and result, and restores the registers.
// ----------------------------------------------------------------------------
module colour_match_bounding_box_top
   import cmbb_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // red [7:0], green [15:8], blue [23:16]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // found [0], box_x [11:1], box_y [22:12], box_width [33:23],
   // box_height [44:34], zero [47:45]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int EW = CW + RW + 2;

   cmbb_cfg_type          cfg_ff, cfg_in;
   cmbb_queue_status_type q_status;
   cmbb_result_type       result;
   logic [EW-1:0]         front_entry, head;
   logic                  accept, back_pop;

   assign csr_ready = !reset;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TARGET_RED:   cfg_in.target_red = csr_data[COLOUR_W-1:0];
            CSR_TARGET_GREEN: cfg_in.target_green = csr_data[COLOUR_W-1:0];
            CSR_TARGET_BLUE:  cfg_in.target_blue = csr_data[COLOUR_W-1:0];
            CSR_TOLERANCE:    cfg_in.tolerance = csr_data[TOL_W-1:0];
            CSR_FRAME_WIDTH:  cfg_in.frame_width = csr_data;
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_red <= '0;
         cfg_ff.target_green <= '0;
         cfg_ff.target_blue <= '0;
         cfg_ff.tolerance <= '0;
         cfg_ff.frame_width <= FRAME_WIDTH_RESET;
         cfg_ff.frame_height <= FRAME_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !reset && !q_status.full;
   assign accept = req_tvalid && req_tready;

   cmbb_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CW         (CW),
      .RW         (RW)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .pixel  (req_tdata),
      .entry  (front_entry)
   );

   cmbb_queue #(
      .WIDTH (EW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_entry),
      .pop       (back_pop),
      .pop_data  (head),
      .status    (q_status)
   );

   cmbb_back #(
      .CW (CW),
      .RW (RW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!q_status.empty),
      .pop        (back_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {3'b000, result};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[44:1] == 44'd0)
      else $error("empty frame result carries a non-zero box");

   assert property (@(posedge clock) disable iff (reset)
      q_status.count != 2'd3)
      else $error("queue occupancy beyond its depth");

   assert property (@(posedge clock) disable iff (reset)
      back_pop |-> !q_status.empty)
      else $error("box tracker popped an empty queue");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && back_pop |-> !head[CW+RW])
      else $error("end of frame consumed while the result is still held");

endmodule
